// ===== hdl/ordered_integer_list_engine_core_macros.svh =====
// Assertion macros for the ordered integer list engine.
// Used by the top level; depends on nothing else.
`ifndef ORDERED_INTEGER_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_INTEGER_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OILE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define OILE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/oile_pkg.sv =====
// Shared types and codes for the ordered integer list engine.
// Used by the entry cell, the top level and the bench; depends on nothing.
package oile_pkg;

  typedef logic signed [31:0] value_t;

  typedef enum logic [2:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_DEL_IDX = 3'd2,
    REQ_DEL_VAL = 3'd3,
    REQ_FIND    = 3'd4,
    REQ_READ    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SCAN
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage

// ===== hdl/oile_cell.sv =====
// One entry cell of the list: holds a value and a registered match flag.
// Depends on oile_pkg.
module oile_cell (
  input  logic                clk,
  input  oile_pkg::cell_ctrl_t ctrl,
  input  oile_pkg::value_t    key,
  input  oile_pkg::value_t    left_data,
  input  oile_pkg::value_t    right_data,
  output oile_pkg::value_t    data,
  output logic                match
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      oile_pkg::CELL_LOAD:  data <= key;
      oile_pkg::CELL_LEFT:  data <= left_data;
      oile_pkg::CELL_RIGHT: data <= right_data;
      default:              data <= data;
    endcase
    if (ctrl.cmp_en) begin
      match <= (data == key);
    end
  end

endmodule

// ===== hdl/ordered_integer_list_engine_core.sv =====
// Ordered integer list engine: a row of entry cells with a shared count.
// Append, insert, delete at index, read and unknown requests load the result
// register as they are accepted; find and delete by value compare in every cell,
// then do first-match select and shift down in the scan state once the result
// register is free. A request is accepted only when idle and the result is free.
// Reset clears the count, the sequencer and the result valid; cell contents stay.
`include "ordered_integer_list_engine_core_macros.svh"

module ordered_integer_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // position[5:0], item_value[37:6], zero pad
  input  logic [2:0]  s_tuser,  // req_type[2:0]
  // Result channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], found_position[7:2],
                                // read_value[39:8], entry_count[46:40], pad
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  // Working width wide enough for the count and for the 6/7-bit fields.
  localparam int PW = (CW > 7) ? CW : 7;

  // The list state: the count of valid leading entries and the sequencer.
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  oile_pkg::fsm_t  state;
  oile_pkg::fsm_t  state_next;
  // Remembers whether the pending scan must also remove the match.
  logic            scan_del;
  logic            scan_del_next;

  // Result register.
  oile_pkg::status_t  out_status;
  logic [5:0]         out_found;
  oile_pkg::value_t   out_read;
  logic [6:0]         out_count;
  oile_pkg::status_t  res_status;
  logic [PW-1:0]      res_found;
  oile_pkg::value_t   res_read;
  logic               out_load;

  // Decoded request fields.
  oile_pkg::req_t     req;
  logic [5:0]         position;
  oile_pkg::value_t   item_value;
  logic [PW-1:0]      pos_ext;
  logic [PW-1:0]      count_ext;
  logic               s_accept;
  logic               full;
  logic               pos_ok;
  logic               out_free;

  // Cell row.
  oile_pkg::cell_ctrl_t ctrl [CAPACITY];
  oile_pkg::value_t     cell_data [CAPACITY];
  logic [CAPACITY-1:0]  cell_match;
  logic [CAPACITY-1:0]  hit_vec;
  logic [CAPACITY-1:0]  first_vec;
  logic                 any_hit;

  assign req        = oile_pkg::req_t'(s_tuser);
  assign position   = s_tdata[5:0];
  assign item_value = s_tdata[37:6];
  assign pos_ext    = PW'(position);
  assign count_ext  = PW'(count);
  assign full       = (count == CW'(CAPACITY));
  assign pos_ok     = (pos_ext < count_ext);
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == oile_pkg::FSM_IDLE) && out_free;
  assign s_accept   = s_tvalid && s_tready;

  // Every cell compares its value against the key during the request cycle.
  // A match only counts below the count; the lowest one wins, isolated with
  // the usual two's complement trick.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      hit_vec[k] = cell_match[k] && (PW'(k) < count_ext);
    end
    first_vec = hit_vec & (~hit_vec + CAPACITY'(1));
    any_hit   = |hit_vec;
    res_found = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (first_vec[k]) begin
        res_found = res_found | PW'(k);
      end
    end
  end

  // Sequencer and cell control.
  always_comb begin
    state_next    = state;
    scan_del_next = scan_del;
    count_next    = count;
    res_status    = oile_pkg::ST_OK;
    res_read      = '0;
    out_load      = 1'b0;
    for (int k = 0; k < CAPACITY; k++) begin
      ctrl[k].op     = oile_pkg::CELL_HOLD;
      ctrl[k].cmp_en = 1'b0;
    end

    unique case (state)
      oile_pkg::FSM_IDLE: begin
        if (s_accept) begin
          out_load = 1'b1;
          case (req)
            oile_pkg::REQ_APPEND: begin
              if (full) begin
                res_status = oile_pkg::ST_FULL;
              end else begin
                for (int k = 0; k < CAPACITY; k++) begin
                  if (PW'(k) == count_ext) ctrl[k].op = oile_pkg::CELL_LOAD;
                end
                count_next = count + CW'(1);
              end
            end
            oile_pkg::REQ_INSERT: begin
              if (!pos_ok) begin
                res_status = oile_pkg::ST_RANGE;
              end else if (full) begin
                res_status = oile_pkg::ST_FULL;
              end else begin
                // The cell at the index takes the new value, later cells
                // take their left neighbor.
                for (int k = 0; k < CAPACITY; k++) begin
                  if (PW'(k) == pos_ext) begin
                    ctrl[k].op = oile_pkg::CELL_LOAD;
                  end else if (PW'(k) > pos_ext) begin
                    ctrl[k].op = oile_pkg::CELL_LEFT;
                  end
                end
                count_next = count + CW'(1);
              end
            end
            oile_pkg::REQ_DEL_IDX: begin
              if (!pos_ok) begin
                res_status = oile_pkg::ST_RANGE;
              end else begin
                for (int k = 0; k < CAPACITY; k++) begin
                  if (PW'(k) >= pos_ext) ctrl[k].op = oile_pkg::CELL_RIGHT;
                end
                count_next = count - CW'(1);
              end
            end
            oile_pkg::REQ_DEL_VAL, oile_pkg::REQ_FIND: begin
              // The result comes out of the scan cycle instead.
              out_load      = 1'b0;
              scan_del_next = (req == oile_pkg::REQ_DEL_VAL);
              state_next    = oile_pkg::FSM_SCAN;
              for (int k = 0; k < CAPACITY; k++) begin
                ctrl[k].cmp_en = 1'b1;
              end
            end
            oile_pkg::REQ_READ: begin
              if (!pos_ok) begin
                res_status = oile_pkg::ST_RANGE;
              end else begin
                res_read = cell_data[pos_ext[IW-1:0]];
              end
            end
            default: begin
              // Unused request codes leave the list alone and report ok.
            end
          endcase
        end
      end
      oile_pkg::FSM_SCAN: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = oile_pkg::FSM_IDLE;
          if (!any_hit) begin
            res_status = oile_pkg::ST_ABSENT;
          end else if (scan_del) begin
            for (int k = 0; k < CAPACITY; k++) begin
              if (PW'(k) >= res_found) ctrl[k].op = oile_pkg::CELL_RIGHT;
            end
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        state_next = oile_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oile_pkg::FSM_IDLE;
      count    <= '0;
      scan_del <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_del <= scan_del_next;
    end
  end

  // Result register; a found index is reported only when a match exists.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) begin
      out_status <= res_status;
      out_found  <= (state == oile_pkg::FSM_SCAN && any_hit) ? 6'(res_found) : 6'd0;
      out_read   <= res_read;
      out_count  <= 7'(PW'(count_next));
    end
  end

  assign m_tdata = {1'b0, out_count, out_read, out_found, out_status};

  // The row of cells; the end cells see their key or themselves at the edges.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    oile_pkg::value_t left_in;
    oile_pkg::value_t right_in;
    if (g == 0) begin : g_first
      assign left_in = item_value;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = cell_data[g];
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    oile_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .key        (item_value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  // Checks on the sequencer and the count.
  `OILE_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY), "count above capacity")
  `OILE_ASSERT_NEXT(a_scan_follows, clk, rst, s_accept && (req == oile_pkg::REQ_DEL_VAL || req == oile_pkg::REQ_FIND), state == oile_pkg::FSM_SCAN, "scan cycle missing")
  `OILE_ASSERT_NEXT(a_count_quiet, clk, rst, !s_accept && state == oile_pkg::FSM_IDLE, $stable(count), "count changed without a request")
  `OILE_ASSERT_NOW(a_full_status, clk, rst, m_tvalid && out_status == oile_pkg::ST_FULL, full, "full status while not full")

endmodule

// ===== test/tb_ordered_integer_list_engine_core.sv =====
// Self-checking bench for the ordered integer list engine core.
// Depends on oile_pkg and ordered_integer_list_engine_core; drives bursty requests,
// stalls the result side and checks every result against a list model kept here.
module tb_ordered_integer_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY       = 64;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 2000;

  // The two request codes the block does not define; it must ignore them.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // Two copies of the list: one steers the generator, one predicts results.
  localparam int GEN_VIEW = 0;
  localparam int CHK_VIEW = 1;

  typedef struct packed {
    logic [2:0]       kind;
    logic [5:0]       position;
    oile_pkg::value_t item_value;
  } list_req_t;

  typedef struct packed {
    oile_pkg::status_t status;
    logic [5:0]        found_position;
    oile_pkg::value_t  read_value;
    logic [6:0]        entry_count;
  } list_result_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_MIXED,
    PH_DRAIN
  } load_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // position[5:0], item_value[37:6], zero pad
  logic [2:0]  s_tuser = '0;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // status[1:0], found_position[7:2],
                               // read_value[39:8], entry_count[46:40], pad

  oile_pkg::value_t list_cells [2][CAPACITY];
  int unsigned      list_count [2];

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  list_req_t    cur_req = '0;
  list_req_t    next_req;
  list_result_t want;

  logic        req_taken = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [15:0] ready_pat = 16'hFFFF;
  int unsigned pat_age = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  load_phase_t      phase;
  int unsigned      phase_left;
  logic             drain_next;
  int unsigned      random_issued;
  int unsigned      roll;
  logic [2:0]       kind;
  oile_pkg::value_t val;

  ordered_integer_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one request to the chosen copy of the list and returns the result
  // the block owes for it. Unknown request codes leave the list alone.
  function automatic list_result_t apply_request(input int which, input list_req_t rq);
    list_result_t res;
    int unsigned  used;
    int unsigned  hit;
    res.status         = oile_pkg::ST_OK;
    res.found_position = '0;
    res.read_value     = '0;
    used = list_count[which];
    case (rq.kind)
      oile_pkg::REQ_APPEND: begin
        if (used >= CAPACITY) begin
          res.status = oile_pkg::ST_FULL;
        end else begin
          list_cells[which][used] = rq.item_value;
          used++;
        end
      end
      oile_pkg::REQ_INSERT: begin
        // The range check wins over the full check.
        if (rq.position >= used) begin
          res.status = oile_pkg::ST_RANGE;
        end else if (used >= CAPACITY) begin
          res.status = oile_pkg::ST_FULL;
        end else begin
          for (int k = used; k > rq.position; k--)
            list_cells[which][k] = list_cells[which][k - 1];
          list_cells[which][rq.position] = rq.item_value;
          used++;
        end
      end
      oile_pkg::REQ_DEL_IDX: begin
        if (rq.position >= used) begin
          res.status = oile_pkg::ST_RANGE;
        end else begin
          for (int k = rq.position; k + 1 < used; k++)
            list_cells[which][k] = list_cells[which][k + 1];
          used--;
        end
      end
      oile_pkg::REQ_DEL_VAL, oile_pkg::REQ_FIND: begin
        hit = used;
        for (int k = used - 1; k >= 0; k--)
          if (list_cells[which][k] == rq.item_value) hit = k;
        if (hit == used) begin
          res.status = oile_pkg::ST_ABSENT;
        end else begin
          res.found_position = hit[5:0];
          if (rq.kind == oile_pkg::REQ_DEL_VAL) begin
            for (int k = hit; k + 1 < used; k++)
              list_cells[which][k] = list_cells[which][k + 1];
            used--;
          end
        end
      end
      oile_pkg::REQ_READ: begin
        if (rq.position >= used) res.status = oile_pkg::ST_RANGE;
        else res.read_value = list_cells[which][rq.position];
      end
      default: ;
    endcase
    list_count[which] = used;
    res.entry_count = used[6:0];
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Mostly small values so that duplicates and matches are common, with
  // full-width random values and the signed extremes mixed in.
  function automatic oile_pkg::value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return oile_pkg::value_t'($urandom_range(0, 15)) - 8;
    endcase
  endfunction

  // For find and delete by value: usually a value the list holds right now.
  function automatic oile_pkg::value_t pick_match_value();
    int unsigned used;
    used = list_count[GEN_VIEW];
    if (used != 0 && $urandom_range(0, 3) != 0)
      return list_cells[GEN_VIEW][$urandom_range(0, used - 1)];
    return pick_value();
  endfunction

  // Mostly a live index; otherwise one past the end or anywhere in the field.
  function automatic logic [5:0] pick_position();
    int unsigned used;
    used = list_count[GEN_VIEW];
    if (used != 0 && $urandom_range(0, 4) != 0) return 6'($urandom_range(0, used - 1));
    if (used < CAPACITY && $urandom_range(0, 1) == 0) return 6'(used);
    return 6'($urandom_range(0, CAPACITY - 1));
  endfunction

  // Queues a request and advances the generator's copy of the list, so that
  // later choices see the state the block will be in when it takes them.
  task automatic queue_request(input logic [2:0] k, input logic [5:0] pos,
                               input oile_pkg::value_t v);
    list_req_t rq;
    rq.kind       = k;
    rq.position   = pos;
    rq.item_value = v;
    void'(apply_request(GEN_VIEW, rq));
    pending_reqs.push_back(rq);
  endtask

  // Request driver: presents the next queued request once the current one has
  // been taken. Requests go out in bursts separated by random gaps; a zero gap
  // joins two bursts into one long back-to-back stretch.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        cur_req  <= next_req;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, next_req.item_value, next_req.position};
        s_tuser  <= next_req.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure: a rotating 16-bit ready pattern, replaced each time
  // the pattern age counter wraps. Some patterns are all ones, others dense or sparse;
  // bit 0 is always set so a stall never lasts a whole pattern.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ready_pat[0];
      if (pat_age == 63) begin
        pat_age <= 0;
        case ($urandom_range(0, 3))
          0:       ready_pat <= 16'hFFFF;
          1:       ready_pat <= 16'($urandom) | 16'h0001;
          2:       ready_pat <= (16'($urandom) & 16'($urandom)) | 16'h0001;
          default: ready_pat <= 16'($urandom) | 16'($urandom) | 16'h0001;
        endcase
      end else begin
        pat_age   <= pat_age + 1;
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
      end
    end
  end

  // Monitor and scoreboard. A result is checked before the request taken at the
  // same edge is predicted, so the oldest expectation is always the right one.
  // The watchdog ends the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      req_taken   <= 1'b0;
      idle_cycles <= 0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %0h", m_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(m_tdata[1:0]));
          compare_field("found_position", 32'(want.found_position), 32'(m_tdata[7:2]));
          compare_field("read_value", want.read_value, m_tdata[39:8]);
          compare_field("entry_count", 32'(want.entry_count), 32'(m_tdata[46:40]));
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(CHK_VIEW, cur_req));
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("** ordered_integer_list_engine_core: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    list_count[GEN_VIEW] = 0;
    list_count[CHK_VIEW] = 0;

    // Directed opening on the empty list: every request type but append out of range or
    // absent, the two unknown codes, then the signed extremes, insert at the
    // head and at the last index, insert one past the end, a duplicate where
    // find must report the first copy, and deletes at the head and the tail.
    queue_request(oile_pkg::REQ_READ,    6'd0,  32'sd0);
    queue_request(oile_pkg::REQ_DEL_IDX, 6'd63, 32'sd0);
    queue_request(oile_pkg::REQ_DEL_VAL, 6'd0,  32'sd5);
    queue_request(oile_pkg::REQ_FIND,    6'd0,  32'sd0);
    queue_request(oile_pkg::REQ_INSERT,  6'd0,  32'sd1);
    queue_request(REQ_SPARE_LO, 6'd0, 32'sd9);
    queue_request(REQ_SPARE_HI, 6'd63, -32'sd1);
    queue_request(oile_pkg::REQ_APPEND,  6'd0,  32'sh8000_0000);
    queue_request(oile_pkg::REQ_APPEND,  6'd0,  32'sh7fff_ffff);
    queue_request(oile_pkg::REQ_APPEND,  6'd0,  32'sd0);
    queue_request(oile_pkg::REQ_APPEND,  6'd0,  -32'sd1);
    queue_request(oile_pkg::REQ_INSERT,  6'd0,  32'sh7fff_ffff);
    queue_request(oile_pkg::REQ_INSERT,  6'd4,  -32'sd1);
    queue_request(oile_pkg::REQ_INSERT,  6'd6,  32'sd3);
    queue_request(oile_pkg::REQ_FIND,    6'd0,  32'sh7fff_ffff);
    queue_request(oile_pkg::REQ_FIND,    6'd0,  -32'sd1);
    queue_request(oile_pkg::REQ_READ,    6'd5,  32'sd0);
    queue_request(oile_pkg::REQ_READ,    6'd6,  32'sd0);
    queue_request(oile_pkg::REQ_DEL_VAL, 6'd0,  32'sh7fff_ffff);
    queue_request(oile_pkg::REQ_DEL_IDX, 6'd4,  32'sd0);
    queue_request(oile_pkg::REQ_DEL_IDX, 6'd0,  32'sd0);
    queue_request(oile_pkg::REQ_READ,    6'd0,  32'sd0);
    queue_request(oile_pkg::REQ_FIND,    6'd0,  32'sd12345);

    // Random part in phases: fill until full and knock on the full list a few
    // times, mix freely, drain until empty and poke the empty list, mix again.
    phase         = PH_FILL;
    phase_left    = $urandom_range(1, 4);
    drain_next    = 1'b1;
    random_issued = 0;
    while (random_issued < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  kind = (roll < 70) ? oile_pkg::REQ_APPEND :
                         (roll < 90) ? oile_pkg::REQ_INSERT :
                         (roll < 95) ? oile_pkg::REQ_READ : oile_pkg::REQ_FIND;
        PH_DRAIN: kind = (roll < 45) ? oile_pkg::REQ_DEL_IDX :
                         (roll < 80) ? oile_pkg::REQ_DEL_VAL :
                         (roll < 90) ? oile_pkg::REQ_READ : oile_pkg::REQ_FIND;
        default:  kind = (roll < 1) ? REQ_SPARE_LO : (roll < 2) ? REQ_SPARE_HI :
                         3'($urandom_range(0, 5));
      endcase
      val = (kind == oile_pkg::REQ_DEL_VAL || kind == oile_pkg::REQ_FIND) ?
            pick_match_value() : pick_value();
      queue_request(kind, pick_position(), val);
      if (kind != REQ_SPARE_LO && kind != REQ_SPARE_HI) random_issued++;

      case (phase)
        PH_FILL: begin
          if (list_count[GEN_VIEW] == CAPACITY) begin
            if (phase_left <= 1) begin
              phase      = PH_MIXED;
              phase_left = $urandom_range(40, 150);
              drain_next = 1'b1;
            end else begin
              phase_left--;
            end
          end
        end
        PH_DRAIN: begin
          if (list_count[GEN_VIEW] == 0) begin
            if (phase_left <= 1) begin
              phase      = PH_MIXED;
              phase_left = $urandom_range(40, 150);
              drain_next = 1'b0;
            end else begin
              phase_left--;
            end
          end
        end
        default: begin
          if (phase_left <= 1) begin
            phase      = drain_next ? PH_DRAIN : PH_FILL;
            phase_left = $urandom_range(1, 4);
          end else begin
            phase_left--;
          end
        end
      endcase
    end

    // Single reset at the start; released at a falling edge like every input.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Let every request go out and every result come back, then keep running
    // so that anything stray the block might still emit is caught.
    while (pending_reqs.size() != 0 || s_tvalid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (mismatches == 0) begin
      $display("** ordered_integer_list_engine_core: PASSED **");
    end else begin
      $display("** ordered_integer_list_engine_core: FAILED **");
    end
    $finish;
  end

endmodule
